@@ hw/rtl/weno_pkg.sv @@
// Shared widths, constants and types for the WENO5 reconstruction pipeline.
// No dependencies; every module of the block imports this package.
package weno_pkg;

  localparam int CELL_W      = 32;
  localparam int FRAC_BITS   = 24;
  localparam int WEIGHT_BITS = 24;
  localparam int NORM_BITS   = 14;

  // smoothness indicator datapath
  localparam int D_W    = 36;
  localparam int U_W    = 35;
  localparam int U_LO_W = 18;
  localparam int U_HI_W = U_W - U_LO_W;
  localparam int SQ_W   = 70;
  localparam int S_W    = 72;

  // leading-one search over the indicators
  localparam int GRP_W  = 8;
  localparam int NGRP   = S_W / GRP_W;
  localparam int GLEN_W = 4;
  localparam int LEN_W  = 7;

  // raw weights
  localparam int T_W   = NORM_BITS + 1;
  localparam int Q_W   = 2 * NORM_BITS + 1;
  localparam int PR_W  = 4 * NORM_BITS + 1;
  localparam int SUM_W = PR_W + 3;

  // normalized weights
  localparam int WGT_W     = WEIGHT_BITS + 1;
  localparam int DIV_STEPS = WEIGHT_BITS + 1;

  // candidates (times six) and the weighted sum
  localparam int P_W    = 37;
  localparam int P_LO_W = 18;
  localparam int P_HI_W = P_W - P_LO_W;
  localparam int ACC_W  = 64;

  // final division by three via reciprocal
  localparam int X_W        = 33;
  localparam int RECIP_W    = 33;
  localparam int RECIP_LO_W = 17;
  localparam int RECIP_HI_W = RECIP_W - RECIP_LO_W;
  localparam int RECIP_SH   = 34;
  localparam int QP_W       = X_W + RECIP_W;

  localparam longint unsigned EPS_RAW =
    ((64'd1 << FRAC_BITS) + 64'd500000) / 64'd1000000;
  localparam longint unsigned EPS_LSB = (EPS_RAW != 64'd0) ? EPS_RAW : 64'd1;
  localparam logic [S_W-1:0] EPS_SCALED =
    S_W'(EPS_LSB * 64'd12 * (64'd1 << FRAC_BITS));

  // rounding: (m + 3*2^W) >> (W+1) then divide by three
  localparam logic [ACC_W-1:0] RND_HALF = ACC_W'(64'd3 << WEIGHT_BITS);
  localparam int               RND_SH   = WEIGHT_BITS + 1;
  // largest pre-division value whose quotient still fits in range
  localparam logic [ACC_W-1:0] X_MAX    = ACC_W'(64'd6442450946);
  localparam logic [RECIP_W-1:0] RECIP_3 = 33'h155555556;

  localparam logic [CELL_W-1:0] CELL_MAX = 32'h7FFF_FFFF;
  localparam logic [CELL_W-1:0] CELL_MIN = 32'h8000_0000;

  typedef logic signed [CELL_W-1:0] cell_t;
  typedef logic signed [P_W-1:0]    cand_t;
  typedef logic [S_W-1:0]           sind_t;
  typedef logic [SUM_W-1:0]         wraw_t;
  typedef logic [WGT_W-1:0]         wgt_t;

endpackage

@@ hw/rtl/weno_smooth.sv @@
// Smoothness indicators and candidate values for three sub-stencils.
// Four register stages; depends on weno_pkg.
module weno_smooth (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_vld,
  input  weno_pkg::cell_t [4:0]       stencil,
  output logic                        out_vld,
  output weno_pkg::sind_t [2:0]       sind,
  output weno_pkg::cand_t [2:0]       cand
);
  import weno_pkg::*;

  logic signed [D_W-1:0] d1 [3];
  logic signed [D_W-1:0] d2 [3];
  logic [U_W-1:0]        u_nxt [6];
  cand_t [2:0]           cand_nxt;

  logic                  va_r, vb_r, vc_r;
  logic [U_W-1:0]        u_r [6];
  cand_t [2:0]           cand_a_r, cand_b_r, cand_c_r;
  logic [2*U_HI_W-1:0]   hh_r [6];
  logic [U_W-1:0]        hl_r [6];
  logic [2*U_LO_W-1:0]   ll_r [6];
  logic [SQ_W-1:0]       sq_r [6];

  always_comb begin
    logic signed [D_W-1:0] a, b, c;
    logic signed [P_W-1:0] e0, e1, e2, e3, e4;
    for (int k = 0; k < 3; k++) begin
      a = D_W'($signed(stencil[k]));
      b = D_W'($signed(stencil[k+1]));
      c = D_W'($signed(stencil[k+2]));
      d1[k] = a - (b <<< 1) + c;
      d2[k] = (a <<< 1) + a - (b <<< 2) + c;
      u_nxt[2*k]   = d1[k][D_W-1] ? U_W'(-d1[k]) : U_W'(d1[k]);
      u_nxt[2*k+1] = d2[k][D_W-1] ? U_W'(-d2[k]) : U_W'(d2[k]);
    end
    e0 = P_W'($signed(stencil[0]));
    e1 = P_W'($signed(stencil[1]));
    e2 = P_W'($signed(stencil[2]));
    e3 = P_W'($signed(stencil[3]));
    e4 = P_W'($signed(stencil[4]));
    cand_nxt[0] = (e0 <<< 1) - e1 * P_W'(7) + e2 * P_W'(11);
    cand_nxt[1] = -e1 + e2 * P_W'(5) + (e3 <<< 1);
    cand_nxt[2] = (e2 <<< 1) + e3 * P_W'(5) - e4;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r    <= 1'b0;
      vb_r    <= 1'b0;
      vc_r    <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      va_r    <= in_vld;
      vb_r    <= va_r;
      vc_r    <= vb_r;
      out_vld <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage A: differences and candidates
      for (int j = 0; j < 6; j++) u_r[j] <= u_nxt[j];
      cand_a_r <= cand_nxt;
      // stage B: partial products of the squares
      for (int j = 0; j < 6; j++) begin
        hh_r[j] <= (2*U_HI_W)'(u_r[j][U_W-1:U_LO_W]) * (2*U_HI_W)'(u_r[j][U_W-1:U_LO_W]);
        hl_r[j] <= U_W'(u_r[j][U_W-1:U_LO_W]) * U_W'(u_r[j][U_LO_W-1:0]);
        ll_r[j] <= (2*U_LO_W)'(u_r[j][U_LO_W-1:0]) * (2*U_LO_W)'(u_r[j][U_LO_W-1:0]);
      end
      cand_b_r <= cand_a_r;
      // stage C: squares
      for (int j = 0; j < 6; j++) begin
        sq_r[j] <= (SQ_W'(hh_r[j]) << (2*U_LO_W)) + (SQ_W'(hl_r[j]) << (U_LO_W+1))
                   + SQ_W'(ll_r[j]);
      end
      cand_c_r <= cand_b_r;
      // stage D: 13*D1^2 + 3*D2^2 + scaled eps
      for (int k = 0; k < 3; k++) begin
        sind[k] <= S_W'(sq_r[2*k]) * S_W'(13) + S_W'(sq_r[2*k+1]) * S_W'(3) + EPS_SCALED;
      end
      cand <= cand_c_r;
    end
  end

endmodule

@@ hw/rtl/weno_norm.sv @@
// Common normalization of the indicators and the raw nonlinear weights.
// Seven register stages; depends on weno_pkg.
module weno_norm (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_vld,
  input  weno_pkg::sind_t [2:0]       sind,
  input  weno_pkg::cand_t [2:0]       cand,
  output logic                        out_vld,
  output weno_pkg::wraw_t [2:0]       wraw,
  output weno_pkg::wraw_t             wsum,
  output weno_pkg::cand_t [2:0]       cand_out
);
  import weno_pkg::*;

  logic [6:0]          v_r;
  logic [S_W-1:0]      or_w;
  logic [GLEN_W-1:0]   glen_nxt [NGRP];
  logic [LEN_W-1:0]    len;
  logic [LEN_W-1:0]    sh_nxt;
  logic [T_W-1:0]      t_nxt [3];

  sind_t [2:0]         se_r, sf_r;
  logic [GLEN_W-1:0]   glen_r [NGRP];
  logic [LEN_W-1:0]    sh_r;
  logic [T_W-1:0]      t_r [3];
  logic [Q_W-1:0]      q_r [3];
  logic [PR_W-1:0]     p_r [3];
  wraw_t [2:0]         w_r;
  cand_t [2:0]         ce_r, cf_r, cg_r, ch_r, ci_r, cj_r;

  // bit length of the largest indicator equals that of their OR
  always_comb begin
    or_w = sind[0] | sind[1] | sind[2];
    for (int g = 0; g < NGRP; g++) begin
      glen_nxt[g] = '0;
      for (int b = 0; b < GRP_W; b++) begin
        if (or_w[g*GRP_W+b]) glen_nxt[g] = GLEN_W'(b + 1);
      end
    end
  end

  always_comb begin
    len = '0;
    for (int g = 0; g < NGRP; g++) begin
      if (glen_r[g] != '0) len = LEN_W'(g * GRP_W) + LEN_W'(glen_r[g]);
    end
    sh_nxt = (len > LEN_W'(NORM_BITS)) ? len - LEN_W'(NORM_BITS) : '0;
  end

  // shift right, rounding up
  always_comb begin
    logic [S_W-1:0] shifted;
    logic [S_W-1:0] mask;
    logic           sticky;
    for (int k = 0; k < 3; k++) begin
      shifted  = sf_r[k] >> sh_r;
      mask     = (S_W'(1) << sh_r) - S_W'(1);
      sticky   = |(sf_r[k] & mask);
      t_nxt[k] = shifted[T_W-1:0] + T_W'(sticky);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[5:0], in_vld};
    end
  end

  assign out_vld = v_r[6];

  always_ff @(posedge clk) begin
    if (en) begin
      se_r <= sind;
      for (int g = 0; g < NGRP; g++) glen_r[g] <= glen_nxt[g];
      ce_r <= cand;

      sf_r <= se_r;
      sh_r <= sh_nxt;
      cf_r <= ce_r;

      for (int k = 0; k < 3; k++) t_r[k] <= t_nxt[k];
      cg_r <= cf_r;

      for (int k = 0; k < 3; k++) q_r[k] <= Q_W'(Q_W'(t_r[k]) * Q_W'(t_r[k]));
      ch_r <= cg_r;

      p_r[0] <= PR_W'(PR_W'(q_r[1]) * PR_W'(q_r[2]));
      p_r[1] <= PR_W'(PR_W'(q_r[0]) * PR_W'(q_r[2]));
      p_r[2] <= PR_W'(PR_W'(q_r[0]) * PR_W'(q_r[1]));
      ci_r <= ch_r;

      // linear weights 1/10, 6/10, 3/10 as 1 : 6 : 3
      w_r[0] <= SUM_W'(p_r[0]);
      w_r[1] <= SUM_W'(p_r[1]) * SUM_W'(6);
      w_r[2] <= SUM_W'(p_r[2]) * SUM_W'(3);
      cj_r <= ci_r;

      wraw     <= w_r;
      wsum     <= w_r[0] + w_r[1] + w_r[2];
      cand_out <= cj_r;
    end
  end

endmodule

@@ hw/rtl/weno_div.sv @@
// Pipelined restoring divider: three weights over a shared sum, one
// quotient bit per stage. Depends on weno_pkg.
module weno_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_vld,
  input  weno_pkg::wraw_t [2:0]       wraw,
  input  weno_pkg::wraw_t             wsum,
  input  weno_pkg::cand_t [2:0]       cand,
  output logic                        out_vld,
  output weno_pkg::wgt_t [2:0]        wgt,
  output weno_pkg::cand_t [2:0]       cand_out
);
  import weno_pkg::*;

  logic [DIV_STEPS-1:0] v_r;
  wraw_t [2:0]          rem_r  [DIV_STEPS];
  wgt_t  [2:0]          quo_r  [DIV_STEPS];
  wraw_t                den_r  [DIV_STEPS];
  cand_t [2:0]          cand_r [DIV_STEPS];

  wraw_t [2:0]          rem_nxt [DIV_STEPS];
  wgt_t  [2:0]          quo_nxt [DIV_STEPS];

  always_comb begin
    logic [SUM_W:0] rr;
    logic           ge;
    // first step: compare the numerator itself
    for (int j = 0; j < 3; j++) begin
      rr            = {1'b0, wraw[j]};
      ge            = rr >= {1'b0, wsum};
      rem_nxt[0][j] = ge ? SUM_W'(rr - {1'b0, wsum}) : SUM_W'(rr);
      quo_nxt[0][j] = WGT_W'(ge);
    end
    for (int k = 1; k < DIV_STEPS; k++) begin
      for (int j = 0; j < 3; j++) begin
        rr            = {rem_r[k-1][j], 1'b0};
        ge            = rr >= {1'b0, den_r[k-1]};
        rem_nxt[k][j] = ge ? SUM_W'(rr - {1'b0, den_r[k-1]}) : SUM_W'(rr);
        quo_nxt[k][j] = {quo_r[k-1][j][WGT_W-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[DIV_STEPS-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r[0]  <= wsum;
      cand_r[0] <= cand;
      for (int k = 1; k < DIV_STEPS; k++) begin
        den_r[k]  <= den_r[k-1];
        cand_r[k] <= cand_r[k-1];
      end
      for (int k = 0; k < DIV_STEPS; k++) begin
        rem_r[k] <= rem_nxt[k];
        quo_r[k] <= quo_nxt[k];
      end
    end
  end

  assign out_vld  = v_r[DIV_STEPS-1];
  assign wgt      = quo_r[DIV_STEPS-1];
  assign cand_out = cand_r[DIV_STEPS-1];

endmodule

@@ hw/rtl/weno_comb.sv @@
// Weighted sum of the candidates, rounding, division by six and saturation.
// Six register stages, the last one is the output register. Depends on weno_pkg.
module weno_comb (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_vld,
  input  weno_pkg::wgt_t [2:0]        wgt,
  input  weno_pkg::cand_t [2:0]       cand,
  output logic                        out_vld,
  output weno_pkg::cell_t             flux
);
  import weno_pkg::*;

  localparam int PLO_W = WGT_W + P_LO_W;
  localparam int PHI_W = WGT_W + 1 + P_HI_W;

  logic [4:0]                v_r;
  logic [PLO_W-1:0]          plo_r [3];
  logic signed [PHI_W-1:0]   phi_r [3];
  logic signed [ACC_W-1:0]   prod_r [3];
  logic signed [ACC_W-1:0]   acc_r;
  logic                      neg_n_r, clamp_n_r, neg_o_r, clamp_o_r;
  logic [X_W-1:0]            x_r;
  logic [X_W+RECIP_LO_W-1:0] ppl_r;
  logic [X_W+RECIP_HI_W-1:0] pph_r;

  logic [ACC_W-1:0]          mag;
  logic [ACC_W-1:0]          x_full;
  logic [QP_W-1:0]           qp;
  logic [CELL_W-1:0]         q;
  logic [CELL_W-1:0]         flux_nxt;

  always_comb begin
    mag    = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
    x_full = (mag + RND_HALF) >> RND_SH;
  end

  always_comb begin
    qp = (QP_W'(pph_r) << RECIP_LO_W) + QP_W'(ppl_r);
    q  = qp[RECIP_SH +: CELL_W];
    if (clamp_o_r) begin
      flux_nxt = neg_o_r ? CELL_MIN : CELL_MAX;
    end else if (neg_o_r) begin
      flux_nxt = -q;
    end else begin
      flux_nxt = (q > CELL_MAX) ? CELL_MAX : q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= '0;
      out_vld <= 1'b0;
    end else if (en) begin
      v_r     <= {v_r[3:0], in_vld};
      out_vld <= v_r[4];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // candidate split as hi*2^18 + lo to keep the multipliers narrow
      for (int k = 0; k < 3; k++) begin
        plo_r[k] <= PLO_W'(wgt[k]) * PLO_W'(cand[k][P_LO_W-1:0]);
        phi_r[k] <= PHI_W'($signed({1'b0, wgt[k]})) * PHI_W'($signed(cand[k][P_W-1:P_LO_W]));
      end
      for (int k = 0; k < 3; k++) begin
        prod_r[k] <= (ACC_W'(phi_r[k]) <<< P_LO_W) + $signed(ACC_W'(plo_r[k]));
      end
      acc_r <= prod_r[0] + prod_r[1] + prod_r[2];

      neg_n_r   <= acc_r[ACC_W-1];
      clamp_n_r <= x_full > X_MAX;
      x_r       <= x_full[X_W-1:0];

      neg_o_r   <= neg_n_r;
      clamp_o_r <= clamp_n_r;
      ppl_r     <= (X_W+RECIP_LO_W)'(x_r) * (X_W+RECIP_LO_W)'(RECIP_3[RECIP_LO_W-1:0]);
      pph_r     <= (X_W+RECIP_HI_W)'(x_r) * (X_W+RECIP_HI_W)'(RECIP_3[RECIP_W-1:RECIP_LO_W]);

      flux <= flux_nxt;
    end
  end

endmodule

@@ hw/rtl/weno5_flux_reconstruction.sv @@
// Top level of the WENO5-JS face reconstruction pipeline.
// Instantiates weno_smooth, weno_norm, weno_div and weno_comb; uses weno_pkg.
//
//   channel | ports                              | direction
//   --------+------------------------------------+----------
//   input   | in_valid, in_ready, in_cell_0..4   | in
//   result  | out_valid, out_ready, out_flux     | out
//
// One item per clock while the output is not stalled; the longest part is
// the 25-stage divider that normalizes the weights (one quotient bit per stage).
// Reset (rst_n low, synchronous) clears the valid bits of every stage.
// While a result waits at the output, all stages hold; in_ready is low then.
module weno5_flux_reconstruction (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  weno_pkg::cell_t        in_cell_0,
  input  weno_pkg::cell_t        in_cell_1,
  input  weno_pkg::cell_t        in_cell_2,
  input  weno_pkg::cell_t        in_cell_3,
  input  weno_pkg::cell_t        in_cell_4,
  output logic                   out_valid,
  input  logic                   out_ready,
  output weno_pkg::cell_t        out_flux
);
  import weno_pkg::*;

  logic        en;
  cell_t [4:0] cells;

  logic        sm_vld, nm_vld, dv_vld;
  sind_t [2:0] sm_sind;
  cand_t [2:0] sm_cand, nm_cand, dv_cand;
  wraw_t [2:0] nm_wraw;
  wraw_t       nm_wsum;
  wgt_t  [2:0] dv_wgt;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign cells    = {in_cell_4, in_cell_3, in_cell_2, in_cell_1, in_cell_0};

  weno_smooth u_smooth (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_valid),
    .stencil (cells),
    .out_vld (sm_vld),
    .sind    (sm_sind),
    .cand    (sm_cand)
  );

  weno_norm u_norm (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (sm_vld),
    .sind     (sm_sind),
    .cand     (sm_cand),
    .out_vld  (nm_vld),
    .wraw     (nm_wraw),
    .wsum     (nm_wsum),
    .cand_out (nm_cand)
  );

  weno_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (nm_vld),
    .wraw     (nm_wraw),
    .wsum     (nm_wsum),
    .cand     (nm_cand),
    .out_vld  (dv_vld),
    .wgt      (dv_wgt),
    .cand_out (dv_cand)
  );

  weno_comb u_comb (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (dv_vld),
    .wgt     (dv_wgt),
    .cand    (dv_cand),
    .out_vld (out_valid),
    .flux    (out_flux)
  );

endmodule

@@ tb/weno5_flux_checker.sv @@
// Checker for the WENO5 face reconstruction block: watches both channels,
// predicts each flux from the accepted stencil and compares in order.
// Depends on weno_pkg for the cell type.
module weno5_flux_checker (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_ready,
  input  weno_pkg::cell_t in_cell_0,
  input  weno_pkg::cell_t in_cell_1,
  input  weno_pkg::cell_t in_cell_2,
  input  weno_pkg::cell_t in_cell_3,
  input  weno_pkg::cell_t in_cell_4,
  input  logic            out_valid,
  input  logic            out_ready,
  input  weno_pkg::cell_t out_flux,
  output int              fail_count,
  output int              pending
);
  import weno_pkg::*;

  localparam int          SHAPE_BITS = 14;
  localparam int          WBITS      = 24;
  localparam int unsigned EPS_ROUND  = ((1 << FRAC_BITS) + 500000) / 1000000;
  localparam int unsigned EPS_UNITS  = (EPS_ROUND != 0) ? EPS_ROUND : 1;

  cell_t flux_queue[$];

  // 12*2^(2F)*beta + eps term, exact
  function automatic logic [127:0] smooth_ind(longint a, longint b, longint c);
    longint       d1, d2;
    logic [127:0] u1, u2;
    d1 = a - 2 * b + c;
    d2 = 3 * a - 4 * b + c;
    u1 = (d1 < 0) ? -d1 : d1;
    u2 = (d2 < 0) ? -d2 : d2;
    return 13 * u1 * u1 + 3 * u2 * u2
           + 128'(EPS_UNITS) * 12 * (128'd1 << FRAC_BITS);
  endfunction

  function automatic logic [63:0] shr_up(logic [127:0] x, int sh);
    logic [127:0] q;
    q = x >> sh;
    if ((q << sh) != x) q = q + 1;
    return q[63:0];
  endfunction

  function automatic cell_t predict_flux(cell_t c0, cell_t c1, cell_t c2,
                                         cell_t c3, cell_t c4);
    longint       a, b, c, d, e, acc, p1, p2, p3;
    logic [127:0] s1, s2, s3, top;
    logic [63:0]  t1, t2, t3, w1, w2, w3, sum, mg, q;
    int           len, sh;
    a = c0; b = c1; c = c2; d = c3; e = c4;
    s1 = smooth_ind(a, b, c);
    s2 = smooth_ind(b, c, d);
    s3 = smooth_ind(c, d, e);
    top = s1;
    if (s2 > top) top = s2;
    if (s3 > top) top = s3;
    len = 0;
    for (int i = 0; i < 128; i++) if (top[i]) len = i + 1;
    sh = (len > SHAPE_BITS) ? len - SHAPE_BITS : 0;
    t1 = shr_up(s1, sh); t2 = shr_up(s2, sh); t3 = shr_up(s3, sh);
    w1 = t2 * t2 * t3 * t3;
    w2 = 6 * t1 * t1 * t3 * t3;
    w3 = 3 * t1 * t1 * t2 * t2;
    sum = w1 + w2 + w3;
    p1 = 2 * a - 7 * b + 11 * c;
    p2 = -b + 5 * c + 2 * d;
    p3 = 2 * c + 5 * d - e;
    acc = longint'((128'(w1) << WBITS) / sum) * p1
        + longint'((128'(w2) << WBITS) / sum) * p2
        + longint'((128'(w3) << WBITS) / sum) * p3;
    mg = (acc < 0) ? -acc : acc;
    q = (mg + (64'd3 << WBITS)) / (64'd6 << WBITS);
    if (acc < 0) return (q > 64'h8000_0000) ? CELL_MIN : cell_t'(-q);
    return (q > 64'h7FFF_FFFF) ? CELL_MAX : cell_t'(q);
  endfunction

  always @(posedge clk) begin
    cell_t want;
    if (!rst_n) begin
      fail_count <= 0;
      flux_queue.delete();
      pending <= 0;
    end else begin
      if (in_valid && in_ready)
        flux_queue.push_back(predict_flux(in_cell_0, in_cell_1, in_cell_2,
                                          in_cell_3, in_cell_4));
      if (out_valid && out_ready) begin
        if (flux_queue.size() == 0) begin
          $display("%0t: unexpected flux item, expected none, actual %h",
                   $time, out_flux);
          fail_count <= fail_count + 1;
        end else begin
          want = flux_queue.pop_front();
          if (want !== out_flux) begin
            $display("%0t: flux mismatch, expected %h, actual %h",
                     $time, want, out_flux);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= flux_queue.size();
    end
  end
endmodule

@@ tb/weno5_flux_reconstruction_test.sv @@
// Top of the WENO5 reconstruction testbench: drives stencils with random
// gaps and stalls, gives the verdict. Uses weno_pkg and weno5_flux_checker.
module weno5_flux_reconstruction_test;
  import weno_pkg::*;

  logic  clk = 0, rst_n = 0, in_valid = 0, out_ready = 0;
  logic  in_ready, out_valid;
  cell_t cell0 = 0, cell1 = 0, cell2 = 0, cell3 = 0, cell4 = 0, out_flux;
  int    fail_count, pending;
  bit    calm = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  weno5_flux_reconstruction dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_cell_0(cell0), .in_cell_1(cell1), .in_cell_2(cell2),
    .in_cell_3(cell3), .in_cell_4(cell4),
    .out_valid(out_valid), .out_ready(out_ready), .out_flux(out_flux));

  weno5_flux_checker chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_cell_0(cell0), .in_cell_1(cell1), .in_cell_2(cell2),
    .in_cell_3(cell3), .in_cell_4(cell4),
    .out_valid(out_valid), .out_ready(out_ready), .out_flux(out_flux),
    .fail_count(fail_count), .pending(pending));

  always @(posedge clk) out_ready <= calm || ($urandom_range(99) >= 30);

  function automatic cell_t pick_cell(int kind, cell_t base);
    case (kind)
      0: return cell_t'($urandom);
      1: return base + cell_t'($signed($urandom_range(2047)) - 1024);
      2: return cell_t'($urandom_range(3)) << 30;
      default: return cell_t'($signed($urandom_range(32'h3FF_FFFF)) - 32'h200_0000);
    endcase
  endfunction

  // in_valid stays high between back-to-back items; it drops only while idling
  task automatic send_stencil(cell_t c0, cell_t c1, cell_t c2, cell_t c3, cell_t c4);
    while (!calm && $urandom_range(99) < 30) begin
      in_valid <= 0;
      @(posedge clk);
    end
    cell0 <= c0; cell1 <= c1; cell2 <= c2; cell3 <= c3; cell4 <= c4;
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin
    cell_t base;
    int    kind;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // extremes, flat, steps, spikes, smooth ramps
    send_stencil(0, 0, 0, 0, 0);
    send_stencil(CELL_MAX, CELL_MAX, CELL_MAX, CELL_MAX, CELL_MAX);
    send_stencil(CELL_MIN, CELL_MIN, CELL_MIN, CELL_MIN, CELL_MIN);
    send_stencil(CELL_MIN, CELL_MAX, CELL_MIN, CELL_MAX, CELL_MIN);
    send_stencil(CELL_MAX, CELL_MIN, CELL_MAX, CELL_MIN, CELL_MAX);
    send_stencil(0, 0, CELL_MAX, CELL_MAX, CELL_MAX);
    send_stencil(0, 0, CELL_MIN, CELL_MIN, CELL_MIN);
    send_stencil(CELL_MAX, CELL_MAX, CELL_MAX, CELL_MIN, CELL_MIN);
    send_stencil(0, 0, 1 << 24, 0, 0);
    send_stencil(1, 2, 3, 4, 5);
    send_stencil(-1, -1, -1, -1, -1);
    send_stencil(1 << 24, 2 << 24, 3 << 24, 4 << 24, 5 << 24);
    send_stencil(0, 1, 0, 1, 0);
    send_stencil(CELL_MIN, 0, CELL_MAX, 0, CELL_MIN);
    send_stencil(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 0);
    // drain fully before the random part
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    for (int n = 0; n < 1000; n++) begin
      calm = (n >= 400 && n < 550);
      kind = $urandom_range(3);
      base = cell_t'($urandom);
      send_stencil(pick_cell(kind, base), pick_cell(kind, base),
                   pick_cell(kind, base), pick_cell(kind, base),
                   pick_cell(kind, base));
    end
    calm = 0;
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule

@@ sim.f @@
hw/rtl/weno_pkg.sv
hw/rtl/weno_smooth.sv
hw/rtl/weno_norm.sv
hw/rtl/weno_div.sv
hw/rtl/weno_comb.sv
hw/rtl/weno5_flux_reconstruction.sv
tb/weno5_flux_checker.sv
tb/weno5_flux_reconstruction_test.sv
